[rtl/grouped_max_rating_table_macros.svh]
// Assertion helpers used by gmrt_back.
`ifndef GROUPED_MAX_RATING_TABLE_MACROS_SVH
`define GROUPED_MAX_RATING_TABLE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/gmrt_pkg.sv]
package gmrt_pkg;

  localparam int ITEM_W  = 8;
  localparam int GROUP_W = 6;
  localparam int RATE_W  = 24;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ITEM_W-1:0]  item_id;
    logic [GROUP_W-1:0] group_id;
    logic [RATE_W-1:0]  rating;
  } in_t;

  typedef struct packed {
    logic [ITEM_W-1:0] best_item;
    logic              status;
  } out_t;

  typedef enum logic [1:0] {
    OPK_INSERT,
    OPK_UPDATE,
    OPK_QUERY,
    OPK_ERROR
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [ITEM_W-1:0]  item_id;
    logic [GROUP_W-1:0] group_id;
    logic [RATE_W-1:0]  rating;
  } op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_flags_t;

endpackage

[rtl/grouped_max_rating_table.sv]
// Grouped max-rating table.
// Input words (in_valid/in_stall/in_data) carry insert, update or query commands;
// each command yields exactly one result word on out_valid/out_stall/out_data,
// in command order. An item is taken when valid is high and stall is low.
// A front stage decodes and range-checks commands into a two-entry queue; the
// back end owns the table (one write port, one registered read port).
// In the back end an insert writes the table and its result together; an update
// reads the entry and writes it back if it is valid; a query walks every table
// entry through the single read port, one entry per cycle. Commands pass through
// the front register and then the queue before they reach the back end.
// After reset the back end clears the table one entry per cycle with in_stall
// held high; results start only after that.
// When out_stall is high the pending result holds in the output register; the
// front and queue keep taking words until both are full, then in_stall rises.
module grouped_max_rating_table import gmrt_pkg::*; #(
  parameter int MAX_ITEMS   = 256,
  parameter int MAX_GROUPS  = 64,
  parameter int RATING_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic     clearing;
  q_flags_t q_flags;
  logic     push;
  op_t      push_op;
  logic     q_pop;
  op_t      q_head;

  gmrt_front #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .clearing (clearing),
    .q_flags  (q_flags),
    .push     (push),
    .push_op  (push_op)
  );

  gmrt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (q_pop),
    .head    (q_head),
    .flags   (q_flags)
  );

  gmrt_back #(
    .MAX_ITEMS   (MAX_ITEMS),
    .RATING_BITS (RATING_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_flags   (q_flags),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/gmrt_front.sv]
module gmrt_front import gmrt_pkg::*; #(
  parameter int MAX_ITEMS  = 256,
  parameter int MAX_GROUPS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_t      in_data,
  input  logic     clearing,
  input  q_flags_t q_flags,
  output logic     push,
  output op_t      push_op
);

  logic     fr_vld_r, fr_vld_nxt;
  op_t      fr_op_r, fr_op_nxt;
  logic     accept;
  logic     id_ok, grp_ok;
  op_kind_t kind;

  assign push     = fr_vld_r && !q_flags.full;
  assign push_op  = fr_op_r;
  assign in_stall = clearing || (fr_vld_r && q_flags.full);
  assign accept   = in_valid && !in_stall;

  assign id_ok  = 32'(in_data.item_id) < 32'(MAX_ITEMS);
  assign grp_ok = 32'(in_data.group_id) < 32'(MAX_GROUPS);

  always_comb begin
    case (in_data.command)
      CMD_INSERT: kind = (id_ok && grp_ok) ? OPK_INSERT : OPK_ERROR;
      CMD_UPDATE: kind = id_ok ? OPK_UPDATE : OPK_ERROR;
      CMD_QUERY:  kind = grp_ok ? OPK_QUERY : OPK_ERROR;
      default:    kind = OPK_ERROR;
    endcase
  end

  always_comb begin
    fr_vld_nxt = fr_vld_r && !push;
    fr_op_nxt  = fr_op_r;
    if (accept) begin
      fr_vld_nxt       = 1'b1;
      fr_op_nxt.kind     = kind;
      fr_op_nxt.item_id  = in_data.item_id;
      fr_op_nxt.group_id = in_data.group_id;
      fr_op_nxt.rating   = in_data.rating;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
    fr_op_r <= fr_op_nxt;
  end

endmodule

[rtl/gmrt_queue.sv]
module gmrt_queue import gmrt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  op_t      push_op,
  input  logic     pop,
  output op_t      head,
  output q_flags_t flags
);

  op_t                slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QPTR_W:0]   CNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

  assign head        = slot_r[rd_ptr_r];
  assign flags.empty = (cnt_r == '0);
  assign flags.full  = (cnt_r == CNT_FULL);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

[rtl/gmrt_back.sv]
`include "grouped_max_rating_table_macros.svh"

module gmrt_back import gmrt_pkg::*; #(
  parameter int MAX_ITEMS   = 256,
  parameter int RATING_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  op_t      q_head,
  input  q_flags_t q_flags,
  output logic     q_pop,
  output logic     clearing,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ITEMS - 1);

  typedef struct packed {
    logic                   vld;
    logic [GROUP_W-1:0]     grp;
    logic [RATING_BITS-1:0] rate;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_CHK,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_t;

  entry_t tbl_r [MAX_ITEMS];
  entry_t mem_rd_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa, mem_ra;
  entry_t             mem_wd;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       clr_r, clr_nxt;
  logic [IDX_W-1:0]       scan_r, scan_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   found_r, found_nxt;
  logic [RATING_BITS-1:0] best_rate_r, best_rate_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  op_kind_t               kind_r, kind_nxt;
  logic [IDX_W-1:0]       cur_idx_r, cur_idx_nxt;
  logic [GROUP_W-1:0]     cur_grp_r, cur_grp_nxt;
  logic [RATING_BITS-1:0] cur_rate_r, cur_rate_nxt;
  out_t                   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;

  logic             out_free;
  logic [IDX_W-1:0] head_idx;
  logic             hit;
  out_t             query_res;

  assign out_free  = !out_valid_r || !out_stall;
  assign head_idx  = IDX_W'(q_head.item_id);
  assign clearing  = (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // scan compare runs in the cycle after the read address
  assign hit = cmp_vld_r && mem_rd_r.vld && (mem_rd_r.grp == cur_grp_r) &&
               (!found_r || (mem_rd_r.rate > best_rate_r));

  always_comb begin
    query_res.best_item = found_r ? ITEM_W'(best_idx_r) : '0;
    query_res.status    = found_r ? STATUS_OK : STATUS_ERR;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    best_rate_nxt = best_rate_r;
    best_idx_nxt  = best_idx_r;
    kind_nxt      = kind_r;
    cur_idx_nxt   = cur_idx_r;
    cur_grp_nxt   = cur_grp_r;
    cur_rate_nxt  = cur_rate_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = clr_r;
    mem_wd        = '0;
    mem_ra        = scan_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        cmp_vld_nxt = 1'b0;
        if (!q_flags.empty) begin
          case (q_head.kind)
            OPK_INSERT: begin
              if (out_free) begin
                q_pop         = 1'b1;
                mem_we        = 1'b1;
                mem_wa        = head_idx;
                mem_wd.vld    = 1'b1;
                mem_wd.grp    = q_head.group_id;
                mem_wd.rate   = RATING_BITS'(q_head.rating);
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{best_item: '0, status: STATUS_OK};
              end
            end
            OPK_ERROR: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{best_item: '0, status: STATUS_ERR};
              end
            end
            OPK_UPDATE: begin
              q_pop        = 1'b1;
              mem_ra       = head_idx;
              kind_nxt     = OPK_UPDATE;
              cur_idx_nxt  = head_idx;
              cur_rate_nxt = RATING_BITS'(q_head.rating);
              state_nxt    = ST_UPD_CHK;
            end
            OPK_QUERY: begin
              q_pop       = 1'b1;
              kind_nxt    = OPK_QUERY;
              cur_grp_nxt = q_head.group_id;
              scan_nxt    = '0;
              found_nxt   = 1'b0;
              state_nxt   = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_UPD_CHK: begin
        if (mem_rd_r.vld) begin
          mem_we      = 1'b1;
          mem_wa      = cur_idx_r;
          mem_wd.vld  = 1'b1;
          mem_wd.grp  = mem_rd_r.grp;
          mem_wd.rate = cur_rate_r;
          res_nxt     = '{best_item: '0, status: STATUS_OK};
        end else begin
          res_nxt     = '{best_item: '0, status: STATUS_ERR};
        end
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        mem_ra      = scan_r;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = scan_r;
        if (scan_r == IDX_LAST) begin
          state_nxt = ST_SCAN_END;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_SCAN_END: begin
        cmp_vld_nxt = 1'b0;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (kind_r == OPK_QUERY) ? query_res : res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (hit) begin
      found_nxt     = 1'b1;
      best_rate_nxt = mem_rd_r.rate;
      best_idx_nxt  = cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r      <= scan_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    best_rate_r <= best_rate_nxt;
    best_idx_r  <= best_idx_nxt;
    kind_r      <= kind_nxt;
    cur_idx_r   <= cur_idx_nxt;
    cur_grp_r   <= cur_grp_nxt;
    cur_rate_r  <= cur_rate_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_r[mem_wa] <= mem_wd;
    end
    mem_rd_r <= tbl_r[mem_ra];
  end

  `ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, !q_flags.empty)
  `ASSERT_IMP(a_no_result_in_clear, clk, rst_n, state_r == ST_CLEAR, !out_valid_r)
  `ASSERT_IMP(a_no_pop_in_scan, clk, rst_n, state_r == ST_SCAN, !q_pop)
  `ASSERT_NXT(a_scan_stays, clk, rst_n, state_r == ST_SCAN, state_r == ST_SCAN || state_r == ST_SCAN_END)

endmodule

[bench/tb_grouped_max_rating_table.sv]
`timescale 1ns / 1ps

module tb_grouped_max_rating_table;
  import gmrt_pkg::*;

  localparam int N_ITEMS      = 256;
  localparam int RANDOM_WORDS = 1150;
  localparam int CALM_TAIL    = 150;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 400;

  // command code the block has no use for
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #10 clk = ~clk;

  grouped_max_rating_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // shadow copy of the item table
  bit                 tbl_valid  [N_ITEMS];
  bit [GROUP_W-1:0]   tbl_group  [N_ITEMS];
  bit [RATE_W-1:0]    tbl_rating [N_ITEMS];

  out_t pending_results[$];
  out_t head;
  int   mismatch_count = 0;
  int   words_sent = 0;
  int   results_seen = 0;
  int   query_hits = 0;
  int   query_misses = 0;
  int   idle_cycles = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic out_t apply_command(input in_t w);
    out_t r;
    bit found;
    bit [RATE_W-1:0] top_rate;
    r.best_item = '0;
    r.status = STATUS_ERR;
    case (w.command)
      CMD_INSERT: begin
        tbl_valid[w.item_id] = 1'b1;
        tbl_group[w.item_id] = w.group_id;
        tbl_rating[w.item_id] = w.rating;
        r.status = STATUS_OK;
      end
      CMD_UPDATE: begin
        if (tbl_valid[w.item_id]) begin
          tbl_rating[w.item_id] = w.rating;
          r.status = STATUS_OK;
        end
      end
      CMD_QUERY: begin
        found = 1'b0;
        top_rate = '0;
        // strict compare keeps the lowest id on a tie
        for (int i = 0; i < N_ITEMS; i++) begin
          if (tbl_valid[i] && tbl_group[i] == w.group_id &&
              (!found || tbl_rating[i] > top_rate)) begin
            found = 1'b1;
            top_rate = tbl_rating[i];
            r.best_item = ITEM_W'(i);
          end
        end
        if (found) begin
          r.status = STATUS_OK;
          query_hits++;
        end else begin
          query_misses++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t row(input logic [CMD_W-1:0] cmd, input logic [ITEM_W-1:0] id,
                                   input logic [GROUP_W-1:0] grp,
                                   input logic [RATE_W-1:0] rate, input bit typed = 1'b0,
                                   input logic [ITEM_W-1:0] best = '0,
                                   input logic status = STATUS_OK);
    dir_row_t d;
    d.word.command = cmd;
    d.word.item_id = id;
    d.word.group_id = grp;
    d.word.rating = rate;
    d.typed = typed;
    d.want.best_item = best;
    d.want.status = status;
    return d;
  endfunction

  // ids cluster at both ends so groups fill up and ties happen
  function automatic logic [ITEM_W-1:0] pick_id();
    case ($urandom_range(0, 2))
      0: return ITEM_W'($urandom_range(0, 11));
      1: return ITEM_W'($urandom_range(248, 255));
      default: return ITEM_W'($urandom());
    endcase
  endfunction

  function automatic logic [GROUP_W-1:0] pick_group();
    case ($urandom_range(0, 2))
      0: return GROUP_W'($urandom_range(0, 2));
      1: return GROUP_W'($urandom_range(61, 63));
      default: return GROUP_W'($urandom());
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rating();
    case ($urandom_range(0, 3))
      0: return RATE_W'($urandom_range(0, 3));
      1: return {RATE_W{1'b1}} - RATE_W'($urandom_range(0, 1));
      default: return RATE_W'($urandom());
    endcase
  endfunction

  function automatic bit find_live(output logic [ITEM_W-1:0] id);
    logic [ITEM_W-1:0] c;
    c = '0;
    for (int k = 0; k < 16; k++) begin
      c = pick_id();
      if (tbl_valid[c]) begin
        id = c;
        return 1'b1;
      end
    end
    id = c;
    return 1'b0;
  endfunction

  function automatic in_t random_word();
    in_t w;
    int sel;
    bit live;
    logic [ITEM_W-1:0] id;
    w.item_id = pick_id();
    w.group_id = pick_group();
    w.rating = pick_rating();
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      w.command = CMD_INSERT;
    end else if (sel < 60) begin
      w.command = CMD_UPDATE;
      if ($urandom_range(0, 4) != 0) begin
        live = find_live(id);
        w.item_id = id;
      end
    end else if (sel < 94) begin
      w.command = CMD_QUERY;
      if ($urandom_range(0, 3) != 0) begin
        live = find_live(id);
        if (live) w.group_id = tbl_group[id];
      end
    end else begin
      w.command = CMD_UNUSED;
    end
    return w;
  endfunction

  task automatic send_word(input in_t w, input bit typed, input out_t want);
    out_t got;
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    got = apply_command(w);
    pending_results.push_back(typed ? want : got);
    words_sent++;
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // result side back-pressure in bursts
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word best_item=%0d status=%0d",
                                  out_data.best_item, out_data.status));
      end else begin
        head = pending_results.pop_front();
        if (out_data.best_item !== head.best_item)
          report_mismatch($sformatf("result %0d best_item %0d, want %0d",
                                    results_seen, out_data.best_item, head.best_item));
        if (out_data.status !== head.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_seen, out_data.status, head.status));
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TIMEOUT: no word moved for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, pending_results.size());
    $display("tb_grouped_max_rating_table failed");
    $finish;
  end

  initial begin
    dir_row_t steer[$];

    // empty table: every lookup fails; then items 0 and 255 go in and are found
    steer.push_back(row(CMD_QUERY, 0, 0, 0, 1, 0, STATUS_ERR));
    steer.push_back(row(CMD_UPDATE, 0, 0, 24'h123456, 1, 0, STATUS_ERR));
    steer.push_back(row(CMD_UPDATE, 255, 63, 24'hFFFFFF, 1, 0, STATUS_ERR));
    steer.push_back(row(CMD_UNUSED, 0, 0, 0, 1, 0, STATUS_ERR));
    steer.push_back(row(CMD_QUERY, 255, 63, 24'hFFFFFF, 1, 0, STATUS_ERR));
    steer.push_back(row(CMD_INSERT, 0, 0, 0, 1, 0, STATUS_OK));
    steer.push_back(row(CMD_INSERT, 255, 63, 24'hFFFFFF, 1, 0, STATUS_OK));
    steer.push_back(row(CMD_QUERY, 0, 0, 24'hFFFFFF, 1, 0, STATUS_OK));
    steer.push_back(row(CMD_QUERY, 0, 63, 0, 1, 255, STATUS_OK));
    // tie on max rating, lower id wins
    steer.push_back(row(CMD_INSERT, 10, 63, 24'hFFFFFF));
    steer.push_back(row(CMD_QUERY, 0, 63, 0));
    steer.push_back(row(CMD_UPDATE, 255, 0, 0));
    steer.push_back(row(CMD_QUERY, 0, 63, 0));
    // tie at zero
    steer.push_back(row(CMD_UPDATE, 10, 63, 0));
    steer.push_back(row(CMD_QUERY, 0, 63, 0));
    // second insert moves item 10 to another group
    steer.push_back(row(CMD_INSERT, 10, 5, 24'h000001));
    steer.push_back(row(CMD_QUERY, 0, 63, 0));
    steer.push_back(row(CMD_QUERY, 0, 5, 0));
    steer.push_back(row(CMD_QUERY, 0, 1, 0, 1, 0, STATUS_ERR));
    steer.push_back(row(CMD_UNUSED, 255, 63, 24'hFFFFFF, 1, 0, STATUS_ERR));
    steer.push_back(row(CMD_INSERT, 128, 0, 24'h800000));
    steer.push_back(row(CMD_QUERY, 0, 0, 0));
    steer.push_back(row(CMD_UPDATE, 0, 0, 24'hFFFFFF));
    steer.push_back(row(CMD_QUERY, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 25;
    stall_pct = 8;
    foreach (steer[i]) begin
      send_word(steer[i].word, steer[i].typed, steer[i].want);
      idle_gap();
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 3;
          default: stall_pct = 12;
        endcase
      end
      // full rate over the last stretch
      if (n >= RANDOM_WORDS - CALM_TAIL) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      send_word(random_word(), 1'b0, '0);
      idle_gap();
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d command words (%0d directed), %0d result words checked",
             words_sent, steer.size(), results_seen);
    $display("Queries: %0d returned a best item, %0d found an empty group",
             query_hits, query_misses);
    if (mismatch_count == 0) begin
      $display("tb_grouped_max_rating_table passed");
    end else begin
      $display("tb_grouped_max_rating_table failed");
    end
    $finish;
  end

endmodule
